[rtl/core/pd_pkg.sv]
package pd_pkg;

   // escape phase codes
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_PCT  = 2'd1;
   localparam logic [1:0] PH_HELD = 2'd2;

   // plus_mode codes
   localparam logic [1:0] PLUS_NONE = 2'd0;
   localparam logic [1:0] PLUS_URL  = 2'd1;
   localparam logic [1:0] PLUS_FORM = 2'd2;

   // error_mode codes
   localparam logic [1:0] ERR_FAIL    = 2'd0;
   localparam logic [1:0] ERR_REPLACE = 2'd1;
   localparam logic [1:0] ERR_IGNORE  = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_HANDLED = 2'd1;
   localparam logic [1:0] ST_FAIL    = 2'd2;
   localparam logic [1:0] ST_BAD     = 2'd3;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] REPL_HI    = 8'hFF;
   localparam logic [7:0] REPL_LO    = 8'hFD;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   // one queued word: up to two result bytes of one input byte
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       two;
      logic       data;
      logic [1:0] status;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   function automatic logic hex_ok(input logic [7:0] c);
      hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] v;
      if (c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c <= 8'h46) begin
         v = c - 8'h37;
      end else begin
         v = c - 8'h57;
      end
      hex_nibble = v[3:0];
   endfunction

   function automatic logic [1:0] raise_status(input logic [1:0] cur, input logic [1:0] s);
      raise_status = (cur < s) ? s : cur;
   endfunction

endpackage

[rtl/core/pd_chan_if.sv]
interface pd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface pd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic [1:0] status;
   logic       out_last;

   modport source (output valid, output out_byte, output byte_valid, output status,
                   output out_last, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input status,
                 input out_last, output ready);
endinterface

[rtl/core/percent_decoder.sv]
// Streaming percent decoder. Takes one encoded byte per word on req_chan (with a last flag)
// and returns decoded bytes on rsp_chan; every result carries the message's sticky status,
// and the final result of a message has out_last set (a status-only word with byte_valid
// low when the last input gives no byte). The input side takes one byte per cycle while
// the queue is not full; each input yields zero, one or two result words in at most one
// entry of a four-entry queue, and the output register drains one word per cycle while
// the consumer is ready, so the sustained rate is one input per cycle unless replacement
// pairs or a stalled consumer fill the queue. A result passes through the queue and then
// the output register. The user must write plus_mode and error_mode through the APB port
// at byte addresses 0 and 4 only while no message is in flight; the block does not enforce it.
module percent_decoder
   import pd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pd_req_if.sink      req_chan,
   pd_rsp_if.source    rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic REG_PLUS  = 1'b0;
   localparam logic REG_ERROR = 1'b1;

   logic [1:0] plus_mode_ff;
   logic [1:0] error_mode_ff;
   logic       csr_write;

   push_type   push;
   entry_type  head;
   logic       q_empty, q_full, pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         plus_mode_ff  <= PLUS_NONE;
         error_mode_ff <= ERR_FAIL;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_PLUS:  plus_mode_ff  <= pwdata[1:0];
            REG_ERROR: error_mode_ff <= pwdata[1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prdata = 32'h0;
      unique case (paddr[2])
         REG_PLUS:  prdata = {30'h0, plus_mode_ff};
         REG_ERROR: prdata = {30'h0, error_mode_ff};
         default:   prdata = 32'h0;
      endcase
   end

   pd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .plus_mode  (plus_mode_ff),
      .error_mode (error_mode_ff),
      .q_full     (q_full),
      .push       (push)
   );

   pd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .empty (q_empty),
      .full  (q_full)
   );

   pd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .q_empty (q_empty),
      .pop     (pop),
      .rsp     (rsp_chan)
   );

endmodule

[rtl/core/pd_front.sv]
module pd_front
   import pd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   pd_req_if.sink     req,
   input  logic [1:0] plus_mode,
   input  logic [1:0] error_mode,
   input  logic       q_full,
   output push_type   push
);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic [1:0] sticky_ff, sticky_in;
   logic       disc_ff, disc_in;

   logic       accept;
   logic       do_plain, do_err, bad, fail, raise1;
   logic       emit_plain, emit_repl, emit_hex;
   logic [7:0] plain_val, hex_val;
   logic [1:0] cnt;
   logic [7:0] ob0, ob1;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   always_comb begin
      do_plain   = 1'b0;
      do_err     = 1'b0;
      bad        = 1'b0;
      fail       = 1'b0;
      raise1     = 1'b0;
      emit_plain = 1'b0;
      emit_repl  = 1'b0;
      emit_hex   = 1'b0;
      plain_val  = req.in_byte;
      hex_val    = {hex_nibble(held_ff), hex_nibble(req.in_byte)};
      phase_in   = PH_IDLE;
      held_in    = held_ff;

      if (error_mode == ERR_FAIL && req.in_byte[7]) begin
         bad = 1'b1;
      end else if (!disc_ff) begin
         unique case (phase_ff)
            PH_IDLE: begin
               do_plain = 1'b1;
            end
            PH_PCT: begin
               if (req.in_last) begin
                  // short escape at end of message
                  if (error_mode == ERR_FAIL || error_mode == ERR_REPLACE) begin
                     do_err = 1'b1;
                  end else begin
                     raise1   = 1'b1;
                     do_plain = 1'b1;
                  end
               end else begin
                  held_in  = req.in_byte;
                  phase_in = PH_HELD;
               end
            end
            PH_HELD: begin
               if (hex_ok(held_ff) && hex_ok(req.in_byte)) begin
                  emit_hex = 1'b1;
               end else begin
                  do_err = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (do_plain) begin
         if (req.in_byte == CH_PLUS && (plus_mode == PLUS_URL || plus_mode == PLUS_FORM)) begin
            emit_plain = 1'b1;
            plain_val  = CH_SPACE;
         end else if (req.in_byte == CH_PERCENT) begin
            if (req.in_last) begin
               do_err = 1'b1;
            end else begin
               phase_in = PH_PCT;
            end
         end else begin
            emit_plain = 1'b1;
         end
      end

      if (do_err) begin
         if (error_mode == ERR_FAIL) begin
            fail     = 1'b1;
            phase_in = PH_IDLE;
         end else begin
            emit_repl = (error_mode == ERR_REPLACE);
            raise1    = 1'b1;
         end
      end

      disc_in   = disc_ff || bad || fail;
      sticky_in = sticky_ff;
      if (raise1) begin
         sticky_in = raise_status(sticky_in, ST_HANDLED);
      end
      if (fail) begin
         sticky_in = raise_status(sticky_in, ST_FAIL);
      end
      if (bad) begin
         sticky_in = raise_status(sticky_in, ST_BAD);
      end

      ob0 = 8'h00;
      ob1 = REPL_LO;
      cnt = 2'd0;
      if (emit_repl) begin
         ob0 = REPL_HI;
         cnt = 2'd2;
      end else if (emit_plain) begin
         ob0 = plain_val;
         cnt = 2'd1;
      end else if (emit_hex) begin
         ob0 = hex_val;
         cnt = 2'd1;
      end
      if (disc_in) begin
         cnt = 2'd0;
         ob0 = 8'h00;
      end
   end

   always_comb begin
      push.valid        = accept && (cnt != 2'd0 || req.in_last);
      push.entry.byte0  = ob0;
      push.entry.byte1  = ob1;
      push.entry.two    = (cnt == 2'd2);
      push.entry.data   = (cnt != 2'd0);
      push.entry.status = sticky_in;
      push.entry.last   = req.in_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         held_ff   <= 8'h00;
         sticky_ff <= ST_OK;
         disc_ff   <= 1'b0;
      end else if (accept) begin
         if (req.in_last) begin
            phase_ff  <= PH_IDLE;
            held_ff   <= 8'h00;
            sticky_ff <= ST_OK;
            disc_ff   <= 1'b0;
         end else begin
            phase_ff  <= phase_in;
            held_ff   <= held_in;
            sticky_ff <= sticky_in;
            disc_ff   <= disc_in;
         end
      end
   end

endmodule

[rtl/core/pd_queue.sv]
module pd_queue
   import pd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   input  logic      pop,
   output entry_type head,
   output logic      empty,
   output logic      full
);

   entry_type        q_mem [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QAW:0]     count_ff;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (QAW+1)'(QDEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = q_mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[rtl/core/pd_back.sv]
module pd_back
   import pd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  entry_type head,
   input  logic      q_empty,
   output logic      pop,
   pd_rsp_if.source  rsp
);

   logic       valid_ff;
   logic       sel_ff, sel_in;
   logic [7:0] byte_ff;
   logic       bvalid_ff;
   logic [1:0] status_ff;
   logic       last_ff;
   logic       load, take;

   assign load   = !valid_ff || rsp.ready;
   assign take   = load && !q_empty;
   // second byte of a pair goes out on the following load
   assign pop    = take && (sel_ff || !head.two);
   assign sel_in = take ? (head.two && !sel_ff) : sel_ff;

   assign rsp.valid      = valid_ff;
   assign rsp.out_byte   = byte_ff;
   assign rsp.byte_valid = bvalid_ff;
   assign rsp.status     = status_ff;
   assign rsp.out_last   = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         sel_ff <= sel_in;
         if (load) begin
            valid_ff <= !q_empty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff   <= sel_ff ? head.byte1 : head.byte0;
         bvalid_ff <= head.data;
         status_ff <= head.status;
         last_ff   <= head.last && (sel_ff || !head.two);
      end
   end

   a_sel_has_pair : assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> (!q_empty && head.two))
      else $error("second half pending without a pair at the queue head");

   a_sel_after_first : assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> valid_ff)
      else $error("second half pending while output register is empty");

   a_status_only_last : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !bvalid_ff) |-> (last_ff && byte_ff == 8'h00))
      else $error("status-only word is not the final word of its message");

endmodule

[dv/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pd_pkg::*;

   localparam logic [2:0] ADDR_PLUS_MODE  = 3'd0;
   localparam logic [2:0] ADDR_ERROR_MODE = 3'd4;
   localparam logic [1:0] PLUS_UNDEF      = 2'd3;
   localparam logic [1:0] ERR_UNDEF       = 2'd3;
   localparam logic [7:0] NON_ASCII       = 8'h80;
   localparam int         WATCHDOG_LIMIT  = 2000;
   localparam int         HOLD_CYCLES     = 100;
   localparam int         NUM_RAND_PHASES = 8;
   localparam int         PHASE_ITEMS     = 110;

   class decode_checker;
      typedef struct {
         logic [7:0] data;
         logic       valid;
         logic [1:0] status;
         logic       last;
      } decoded_word_type;

      logic [1:0]       plus_mode;
      logic [1:0]       error_mode;
      logic [1:0]       esc_phase;
      logic [7:0]       held_digit;
      logic [1:0]       msg_status;
      logic             discarding;
      logic [7:0]       step_bytes[$];
      decoded_word_type pending_words[$];
      int               fails;

      function new();
         plus_mode  = PLUS_NONE;
         error_mode = ERR_FAIL;
         esc_phase  = PH_IDLE;
         held_digit = 8'h00;
         msg_status = ST_OK;
         discarding = 1'b0;
         fails      = 0;
      endfunction

      function void raise_to(logic [1:0] s);
         if (msg_status < s) msg_status = s;
      endfunction

      function int hex_digit(logic [7:0] c);
         if (c >= "0" && c <= "9") return int'(c - "0");
         if (c >= "A" && c <= "F") return int'(c - "A") + 10;
         if (c >= "a" && c <= "f") return int'(c - "a") + 10;
         return -1;
      endfunction

      // shared by bad pairs and short escapes
      function void escape_error();
         if (error_mode == ERR_FAIL) begin
            raise_to(ST_FAIL);
            discarding = 1'b1;
            esc_phase  = PH_IDLE;
         end else begin
            if (error_mode == ERR_REPLACE) begin
               step_bytes.push_back(REPL_HI);
               step_bytes.push_back(REPL_LO);
            end
            raise_to(ST_HANDLED);
         end
      endfunction

      function void plain_byte(logic [7:0] b, logic last);
         if (b == CH_PLUS && (plus_mode == PLUS_URL || plus_mode == PLUS_FORM)) begin
            step_bytes.push_back(CH_SPACE);
         end else if (b == CH_PERCENT) begin
            if (last) escape_error();
            else esc_phase = PH_PCT;
         end else begin
            step_bytes.push_back(b);
         end
      endfunction

      function void note_input(logic [7:0] b, logic last);
         decoded_word_type w;
         int               hi;
         int               lo;
         step_bytes.delete();
         if (error_mode == ERR_FAIL && b >= NON_ASCII) begin
            raise_to(ST_BAD);
            discarding = 1'b1;
            esc_phase  = PH_IDLE;
         end else if (!discarding) begin
            if (esc_phase == PH_IDLE) begin
               plain_byte(b, last);
            end else if (esc_phase == PH_PCT) begin
               if (last) begin
                  esc_phase = PH_IDLE;
                  if (error_mode == ERR_FAIL || error_mode == ERR_REPLACE) begin
                     escape_error();
                  end else begin
                     // ignore: drop the percent, the final byte is literal
                     raise_to(ST_HANDLED);
                     plain_byte(b, last);
                  end
               end else begin
                  held_digit = b;
                  esc_phase  = PH_HELD;
               end
            end else begin
               hi        = hex_digit(held_digit);
               lo        = hex_digit(b);
               esc_phase = PH_IDLE;
               if (hi >= 0 && lo >= 0) step_bytes.push_back({hi[3:0], lo[3:0]});
               else escape_error();
            end
         end
         if (discarding) step_bytes.delete();
         foreach (step_bytes[i]) begin
            w.data   = step_bytes[i];
            w.valid  = 1'b1;
            w.status = msg_status;
            w.last   = last && (i == step_bytes.size() - 1);
            pending_words.push_back(w);
         end
         if (last) begin
            if (step_bytes.size() == 0) begin
               // status-only word closes the message
               w.data   = 8'h00;
               w.valid  = 1'b0;
               w.status = msg_status;
               w.last   = 1'b1;
               pending_words.push_back(w);
            end
            esc_phase  = PH_IDLE;
            held_digit = 8'h00;
            msg_status = ST_OK;
            discarding = 1'b0;
         end
      endfunction

      function void check_word(logic [7:0] d, logic v, logic [1:0] s, logic l);
         decoded_word_type w;
         if (pending_words.size() == 0) begin
            $error("word with nothing pending: out_byte %02h byte_valid %0b status %0d last %0b",
                   d, v, s, l);
            fails++;
         end else begin
            w = pending_words.pop_front();
            if (d !== w.data) begin
               $error("out_byte: expected %02h, actual %02h", w.data, d);
               fails++;
            end
            if (v !== w.valid) begin
               $error("byte_valid: expected %0b, actual %0b", w.valid, v);
               fails++;
            end
            if (s !== w.status) begin
               $error("status: expected %0d, actual %0d", w.status, s);
               fails++;
            end
            if (l !== w.last) begin
               $error("out_last: expected %0b, actual %0b", w.last, l);
               fails++;
            end
         end
      endfunction
   endclass

   typedef struct {
      logic [7:0] data;
      logic       last;
   } enc_byte_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   pd_req_if req_chan();
   pd_rsp_if rsp_chan();

   decode_checker sb = new();
   enc_byte_type  stim_items[$];
   logic          no_gaps = 1'b0;
   logic          hold_off_req = 1'b0;

   percent_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            sb.note_input(req_chan.in_byte, req_chan.in_last);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_word(rsp_chan.out_byte, rsp_chan.byte_valid, rsp_chan.status,
                          rsp_chan.out_last);
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $error("no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // result side: random stall per word, one long hold-off on request
   initial begin : rsp_side
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = no_gaps ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   task automatic add(input logic [7:0] b, input logic l);
      enc_byte_type e;
      e.data = b;
      e.last = l;
      stim_items.push_back(e);
   endtask

   function automatic logic [7:0] rand_hex();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'("0" + v);
      if ($urandom_range(0, 1) == 1) return 8'("a" + v - 10);
      return 8'("A" + v - 10);
   endfunction

   task automatic add_random_message();
      int tokens;
      int r;
      tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
      for (int i = 0; i < tokens; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            add(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
         end else if (r < 62) begin
            add(CH_PERCENT, 1'b0);
            add(rand_hex(), 1'b0);
            add(rand_hex(), 1'b0);
         end else if (r < 70) begin
            add(CH_PLUS, 1'b0);
         end else if (r < 75) begin
            add(8'($urandom_range(0, 255)), 1'b0);
         end else if (r < 79) begin
            add(8'h00, 1'b0);
         end else if (r < 90) begin
            // pair that may or may not be hex
            add(CH_PERCENT, 1'b0);
            add(($urandom_range(0, 1) == 1) ? rand_hex() : 8'($urandom_range(0, 255)), 1'b0);
            add(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
         end else begin
            add(CH_PERCENT, 1'b0);
            add(CH_PERCENT, 1'b0);
         end
      end
      // short escape at the tail now and then
      r = $urandom_range(0, 9);
      if (r == 0) begin
         add(CH_PERCENT, 1'b0);
      end else if (r == 1) begin
         add(CH_PERCENT, 1'b0);
         add(($urandom_range(0, 1) == 1) ? rand_hex() : 8'($urandom_range(0, 255)), 1'b0);
      end
      stim_items[stim_items.size() - 1].last = 1'b1;
   endtask

   task automatic send_item(input logic [7:0] b, input logic l, input int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      req_chan.in_last <= l;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (sb.pending_words.size() != 0);
   endtask

   // send the queued bytes; optional pause until all results are back
   task automatic send_all(input int pause_at);
      enc_byte_type e;
      int           idx;
      idx = 0;
      while (stim_items.size() != 0) begin
         e = stim_items.pop_front();
         if (idx == pause_at) begin
            req_chan.valid <= 1'b0;
            wait_drained();
         end
         send_item(e.data, e.last, no_gaps ? 0 : $urandom_range(0, 12));
         idx++;
      end
      req_chan.valid <= 1'b0;
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [1:0] value);
      logic [31:0] word;
      word      = $urandom();
      word[1:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[1:0] !== value) begin
         $error("prdata at %0d: expected %0d, actual %0d", addr, value, prdata[1:0]);
         sb.fails++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_modes(input logic [1:0] pm, input logic [1:0] em);
      wait_drained();
      // let anything still inside the block settle
      repeat (4) @(posedge clock);
      write_csr(ADDR_PLUS_MODE, pm);
      sb.plus_mode = pm;
      write_csr(ADDR_ERROR_MODE, em);
      sb.error_mode = em;
   endtask

   initial begin : main
      logic [1:0] pm_list[NUM_RAND_PHASES];
      logic [1:0] em_list[NUM_RAND_PHASES];
      pm_list = '{PLUS_NONE, PLUS_URL, PLUS_FORM, PLUS_UNDEF,
                  PLUS_FORM, PLUS_NONE, PLUS_URL, PLUS_UNDEF};
      em_list = '{ERR_FAIL, ERR_REPLACE, ERR_IGNORE, ERR_UNDEF,
                  ERR_FAIL, ERR_IGNORE, ERR_REPLACE, ERR_FAIL};
      reset            <= 1'b1;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= ADDR_PLUS_MODE;
      pwdata           <= 32'h0;
      req_chan.valid   <= 1'b0;
      req_chan.in_byte <= 8'h00;
      req_chan.in_last <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plus as space, fail mode: decode, non-ascii, bad pair, short escape
      apply_modes(PLUS_URL, ERR_FAIL);
      add(CH_PLUS, 1'b0); add(CH_PERCENT, 1'b0); add("4", 1'b0); add("a", 1'b1);
      add(8'h00, 1'b0); add(8'hFF, 1'b1);
      add(CH_PERCENT, 1'b0); add("G", 1'b0); add("1", 1'b0); add(8'hC3, 1'b1);
      add(CH_PERCENT, 1'b1);
      send_all(-1);

      // form, replace mode: bad pair, short escapes, high byte passes
      apply_modes(PLUS_FORM, ERR_REPLACE);
      add(CH_PERCENT, 1'b0); add("z", 1'b0); add("z", 1'b1);
      add(CH_PERCENT, 1'b0); add("4", 1'b1);
      add(CH_PERCENT, 1'b1);
      add(8'h80, 1'b0); add(CH_PLUS, 1'b1);
      send_all(-1);

      // plain url, ignore mode: short escape tail kept, double percent, FF
      apply_modes(PLUS_NONE, ERR_IGNORE);
      add(CH_PERCENT, 1'b0); add("q", 1'b1);
      add(CH_PERCENT, 1'b0); add(CH_PERCENT, 1'b0); add("4", 1'b0);
      add(CH_PERCENT, 1'b0); add("F", 1'b0); add("f", 1'b0); add(CH_PLUS, 1'b1);
      send_all(-1);

      for (int p = 0; p < NUM_RAND_PHASES; p++) begin
         apply_modes(pm_list[p], em_list[p]);
         no_gaps = (p == 2 || p == 6);
         if (p == 2) hold_off_req = 1'b1;
         while (stim_items.size() < PHASE_ITEMS) add_random_message();
         send_all((p == 5) ? PHASE_ITEMS / 2 : -1);
      end
      no_gaps = 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.pending_words.size() != 0) begin
         $error("%0d result words never arrived", sb.pending_words.size());
         sb.fails++;
      end
      if (sb.fails == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

[percent_decoder.f]
rtl/core/pd_pkg.sv
rtl/core/pd_chan_if.sv
rtl/core/pd_front.sv
rtl/core/pd_queue.sv
rtl/core/pd_back.sv
rtl/core/percent_decoder.sv
dv/tb.sv
